@@ hdl/assert_macros.svh @@
// Assertion macros shared by the curve evaluator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hdl/hcpe_pkg.sv @@
// Package for the Hermite curve point evaluator: widths, constants, state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcpe_pkg;
   localparam int COORD_BITS = 18;
   localparam int INDEX_BITS = 10;
   localparam int STEP_BITS  = 16;
   localparam int FRAC_SHIFT = 16;
   localparam int T_BITS     = FRAC_SHIFT + 1;
   localparam int TRAW_BITS  = INDEX_BITS + STEP_BITS;
   // coefficient and accumulator width: A is at most 6x a coordinate, plus Horner growth
   localparam int ACC_BITS   = COORD_BITS + 6;
   localparam int PROD_BITS  = ACC_BITS + T_BITS + 1;
   localparam int CNT_BITS   = $clog2(PROD_BITS + 1);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(655);
   localparam logic [TRAW_BITS-1:0] T_ONE = TRAW_BITS'(65536);
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COEF,
      ST_MUL,
      ST_ADD,
      ST_NEXT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

@@ hdl/hcpe_serial_mul.sv @@
// Bit-serial signed by unsigned multiplier: one bit of t per cycle.
// Depends on hcpe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hcpe_serial_mul (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [hcpe_pkg::ACC_BITS-1:0] mcand,
   input  wire logic        [hcpe_pkg::T_BITS-1:0]   mplier,
   output logic                                     done,
   output logic signed [hcpe_pkg::PROD_BITS-1:0]     product
);
   import hcpe_pkg::*;

   logic                           busy_ff, busy_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic [T_BITS-1:0]              mp_ff, mp_in;
   logic signed [PROD_BITS-1:0]    mc_ff, mc_in;
   logic signed [PROD_BITS-1:0]    acc_ff, acc_in;
   logic                           done_ff, done_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mp_in   = mp_ff;
      mc_in   = mc_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mp_in   = mplier;
         mc_in   = PROD_BITS'(mcand);
         acc_in  = '0;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mp_in  = mp_ff >> 1;
         mc_in  = mc_ff <<< 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(T_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mp_ff  <= mp_in;
      mc_ff  <= mc_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   `ASSERT_CLK(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without busy")
   `ASSERT_CLK(a_no_start_busy, clock, reset, start |-> !busy_ff, "start while busy")
   `ASSERT_CLK(a_cnt_range, clock, reset, busy_ff |-> cnt_ff < CNT_BITS'(T_BITS), "count overrun")
endmodule
`default_nettype wire

@@ hdl/hermite_curve_point_eval_unit.sv @@
// Top level of the Hermite curve point evaluator: control store, sequencer, output register.
// Depends on hcpe_pkg, hcpe_serial_mul and assert_macros.svh.
//
//  channel | ports                                   | dir
//  req     | req_valid/req_stall, command..point_index | in
//  rsp     | rsp_valid/rsp_stall, out_x..beyond_end    | out
//  csr     | csr_write_enable/csr_write_data           | in
//
// A load writes its slot's three coordinates and leaves the sequencer idle. An evaluate
// walks the sequencer per axis: one coefficient state, three multiplies each followed by
// an add state, and one store state; then a done state posts the result on rsp_valid.
// The next item is taken the cycle after the result transfers, so evaluates do not overlap.
// Synchronous reset clears the control vectors and sets the step to 655.
// A stalled result holds, and the next item waits until it transfers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hermite_curve_point_eval_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_command,
   input  wire logic [1:0]                            req_slot,
   input  wire logic signed [hcpe_pkg::COORD_BITS-1:0] req_vec_x,
   input  wire logic signed [hcpe_pkg::COORD_BITS-1:0] req_vec_y,
   input  wire logic signed [hcpe_pkg::COORD_BITS-1:0] req_vec_z,
   input  wire logic [hcpe_pkg::INDEX_BITS-1:0]       req_point_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [hcpe_pkg::COORD_BITS-1:0]      rsp_out_x,
   output logic signed [hcpe_pkg::COORD_BITS-1:0]      rsp_out_y,
   output logic signed [hcpe_pkg::COORD_BITS-1:0]      rsp_out_z,
   output logic                                       rsp_beyond_end,
   input  wire logic                                  csr_write_enable,
   input  wire logic [hcpe_pkg::STEP_BITS-1:0]        csr_write_data
);
   import hcpe_pkg::*;

   localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1) <<< (FRAC_SHIFT - 1);
   localparam logic signed [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] vec_ff [12];
   logic [STEP_BITS-1:0]         step_ff;
   state_type                    state_ff, state_in;
   logic [1:0]                   axis_ff, axis_in;
   logic [1:0]                   pass_ff, pass_in;
   logic [T_BITS-1:0]            t_ff, t_in;
   logic                         beyond_ff, beyond_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]   cb_ff, cb_in;
   logic signed [COORD_BITS-1:0] res_ff [3];
   logic signed [COORD_BITS-1:0] res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_beyond_ff;
   logic                         mul_start;
   logic                         mul_done;
   logic signed [PROD_BITS-1:0]  mul_prod;
   logic [TRAW_BITS-1:0]         traw;
   logic                         take;
   logic                         load_take;
   logic                         eval_take;
   logic signed [ACC_BITS-1:0]   p0, p1, tg0, tg1, ca, cbv, addend;
   logic signed [PROD_BITS-1:0]  rounded;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign take      = req_valid && !req_stall;
   assign load_take = take && (req_command == CMD_LOAD);
   assign eval_take = take && (req_command == CMD_EVAL);
   assign traw      = TRAW_BITS'(req_point_index) * TRAW_BITS'(step_ff);

   assign p0  = ACC_BITS'(vec_ff[{2'd0, axis_ff}]);
   assign p1  = ACC_BITS'(vec_ff[4'd3 + {2'd0, axis_ff}]);
   assign tg0 = ACC_BITS'(vec_ff[4'd6 + {2'd0, axis_ff}]);
   assign tg1 = ACC_BITS'(vec_ff[4'd9 + {2'd0, axis_ff}]);
   assign ca  = (p0 <<< 1) - (p1 <<< 1) + tg0 + tg1;
   assign cbv = (p1 - p0) + ((p1 - p0) <<< 1) - (tg0 <<< 1) - tg1;
   assign rounded = (mul_prod + HALF) >>> FRAC_SHIFT;

   always_comb begin
      unique case (pass_ff)
         2'd0:    addend = cb_ff;
         2'd1:    addend = tg0;
         default: addend = p0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (eval_take) state_in = ST_COEF;
         ST_COEF: state_in = ST_MUL;
         ST_MUL:  if (mul_done) state_in = ST_ADD;
         ST_ADD:  state_in = (pass_ff == 2'd2) ? ST_NEXT : ST_MUL;
         ST_NEXT: state_in = (axis_ff == 2'd2) ? ST_DONE : ST_COEF;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      axis_in      = axis_ff;
      pass_in      = pass_ff;
      t_in         = t_ff;
      beyond_in    = beyond_ff;
      acc_in       = acc_ff;
      cb_in        = cb_ff;
      mul_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      res_in       = (acc_ff > ACC_BITS'(SAT_HI)) ? SAT_HI :
                     (acc_ff < ACC_BITS'(SAT_LO)) ? SAT_LO : COORD_BITS'(acc_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (eval_take) begin
               axis_in   = 2'd0;
               beyond_in = traw > T_ONE;
               t_in      = (traw > T_ONE) ? T_BITS'(T_ONE) : T_BITS'(traw);
            end
         end
         ST_COEF: begin
            acc_in    = ca;
            cb_in     = cbv;
            pass_in   = 2'd0;
            mul_start = 1'b1;
         end
         ST_MUL: ;
         ST_ADD: begin
            acc_in = ACC_BITS'(rounded) + addend;
            if (pass_ff != 2'd2) begin
               pass_in   = pass_ff + 2'd1;
               mul_start = 1'b1;
            end
         end
         ST_NEXT: axis_in = axis_ff + 2'd1;
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   hcpe_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (acc_in),
      .mplier  (t_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_RESET;
         for (int i = 0; i < 12; i++) begin
            vec_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
         if (load_take) begin
            vec_ff[{req_slot, 2'b00} - {2'b00, req_slot}] <= req_vec_x;
            vec_ff[{req_slot, 2'b00} - {2'b00, req_slot} + 4'd1] <= req_vec_y;
            vec_ff[{req_slot, 2'b00} - {2'b00, req_slot} + 4'd2] <= req_vec_z;
         end
      end
      axis_ff   <= axis_in;
      pass_ff   <= pass_in;
      t_ff      <= t_in;
      beyond_ff <= beyond_in;
      acc_ff    <= acc_in;
      cb_ff     <= cb_in;
      if (state_ff == ST_NEXT) begin
         res_ff[axis_ff] <= res_in;
      end
      if (state_ff == ST_DONE) begin
         rsp_beyond_ff <= beyond_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = res_ff[0];
   assign rsp_out_y      = res_ff[1];
   assign rsp_out_z      = res_ff[2];
   assign rsp_beyond_end = rsp_beyond_ff;

   `ASSERT_CLK(a_hold_rsp, clock, reset, rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_out_x), "result dropped")
   `ASSERT_CLK(a_stall_busy, clock, reset, (state_ff != ST_IDLE) |-> req_stall, "took item while busy")
   `ASSERT_CLK(a_axis_range, clock, reset, axis_ff != 2'd3 || state_ff == ST_IDLE || state_ff == ST_DONE, "axis out of range")
endmodule
`default_nettype wire
